// File: rtl/sunt_pkg.sv
// Package of shared types and constants for the strongest unique network table.
package sunt_pkg;

    localparam int NAME_BYTES = 32;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_REPORT = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_MIN_RD,
        S_MIN_CMP,
        S_WRITE,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_SHIFT,
        S_SORT_PUT,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_EMPTY_OUT
    } t_state;

    typedef struct packed {
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [5:0]  len;
        logic signed [15:0] sig;
        logic [7:0]  chan;
        logic [7:0]  sec;
    } t_row;

    function automatic logic [63:0] byte_mask(input logic [5:0] len, input int w);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if ({1'b0, len} > 7'((w * 8) + b)) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/strongest_unique_network_table_core.sv
// Top level of the strongest unique network table with its sequencer and row memory.
// Keeps up to MAX_ROWS networks, one row per name, each holding the strongest signal
// seen. A report walks the stored rows, each by a registered memory read and then a
// compare, and a full table with a new name adds another pass over all MAX_ROWS rows
// to find the weakest row. A finish sorts the rows in place by insertion, one row
// read or moved at a time, then delivers the result items one at a time, each by a
// row read and then an output that waits while the output is stalled. The block takes
// no new item until the current one is finished and its last result has been taken.
// There is no clearing pass: rows at or above the count are never read.
module strongest_unique_network_table_core #(
    parameter int MAX_ROWS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_name_word0,
    input  logic [63:0] i_name_word1,
    input  logic [63:0] i_name_word2,
    input  logic [63:0] i_name_word3,
    input  logic [5:0]  i_name_length,
    input  logic signed [15:0] i_signal_dbm,
    input  logic [7:0]  i_radio_channel,
    input  logic [7:0]  i_security_mode,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_name_word0,
    output logic [63:0] o_out_name_word1,
    output logic [63:0] o_out_name_word2,
    output logic [63:0] o_out_name_word3,
    output logic [5:0]  o_out_name_length,
    output logic signed [15:0] o_out_signal_dbm,
    output logic [7:0]  o_out_channel,
    output logic [7:0]  o_out_security,
    output logic        o_row_valid,
    output logic        o_last_row
);

    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    sunt_pkg::t_row r_mem [MAX_ROWS];

    sunt_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;      // scan index, or j during sort
    logic [CW-1:0] r_outer, n_outer;  // i during sort
    logic [IW-1:0] r_slot, n_slot;
    sunt_pkg::t_row r_new, n_new;     // incoming row, or the row being moved
    sunt_pkg::t_row r_rd;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    sunt_pkg::t_row wr_data;
    logic          r_oval, n_oval;
    logic          r_olast, n_olast;
    logic          r_orv, n_orv;
    sunt_pkg::t_row r_out, n_out;
    sunt_pkg::t_row in_row;
    logic          accept;

    // A result still waiting in the output register holds off the next item, since
    // the weakest-row search borrows that register.
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != sunt_pkg::S_IDLE) || r_oval;

    always_comb begin
        in_row.w0   = i_name_word0 & sunt_pkg::byte_mask(i_name_length, 0);
        in_row.w1   = i_name_word1 & sunt_pkg::byte_mask(i_name_length, 1);
        in_row.w2   = i_name_word2 & sunt_pkg::byte_mask(i_name_length, 2);
        in_row.w3   = i_name_word3 & sunt_pkg::byte_mask(i_name_length, 3);
        in_row.len  = i_name_length;
        in_row.sig  = i_signal_dbm;
        in_row.chan = i_radio_channel;
        in_row.sec  = i_security_mode;
    end

    // Row memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sunt_pkg::S_IDLE;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_oval  <= n_oval;
        end
        r_idx   <= n_idx;
        r_outer <= n_outer;
        r_slot  <= n_slot;
        r_new   <= n_new;
        r_olast <= n_olast;
        r_orv   <= n_orv;
        r_out   <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_outer = r_outer;
        n_slot  = r_slot;
        n_new   = r_new;
        n_oval  = r_oval;
        n_olast = r_olast;
        n_orv   = r_orv;
        n_out   = r_out;
        rd_addr = r_idx[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = r_new;
        case (r_state)
            sunt_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    case (sunt_pkg::t_opcode'(i_opcode))
                        sunt_pkg::OP_START: n_count = '0;
                        sunt_pkg::OP_REPORT: begin
                            if (i_name_length != 6'd0 &&
                                i_name_length <= 6'(sunt_pkg::NAME_BYTES)) begin
                                n_new   = in_row;
                                n_state = (r_count == '0) ? sunt_pkg::S_WRITE
                                                          : sunt_pkg::S_SRCH_RD;
                                n_slot  = '0;
                                if (r_count == '0) n_count = CW'(1);
                            end
                        end
                        sunt_pkg::OP_FINISH: begin
                            if (r_count == '0) begin
                                n_state = sunt_pkg::S_EMPTY_OUT;
                            end else if (r_count == CW'(1)) begin
                                n_state = sunt_pkg::S_EMIT_RD;
                            end else begin
                                n_outer = CW'(1);
                                n_idx   = CW'(1);
                                n_state = sunt_pkg::S_SORT_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sunt_pkg::S_SRCH_RD: n_state = sunt_pkg::S_SRCH_CMP;
            sunt_pkg::S_SRCH_CMP: begin
                if (r_rd.len == r_new.len && r_rd.w0 == r_new.w0 && r_rd.w1 == r_new.w1 &&
                    r_rd.w2 == r_new.w2 && r_rd.w3 == r_new.w3) begin
                    n_slot  = r_idx[IW-1:0];
                    n_state = (r_new.sig > r_rd.sig) ? sunt_pkg::S_WRITE
                                                     : sunt_pkg::S_IDLE;
                end else if (r_idx + CW'(1) < r_count) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = sunt_pkg::S_SRCH_RD;
                end else if (r_count < CW'(MAX_ROWS)) begin
                    n_slot  = r_count[IW-1:0];
                    n_count = r_count + CW'(1);
                    n_state = sunt_pkg::S_WRITE;
                end else begin
                    n_idx   = '0;
                    n_slot  = '0;
                    n_state = sunt_pkg::S_MIN_RD;
                end
            end
            sunt_pkg::S_MIN_RD: n_state = sunt_pkg::S_MIN_CMP;
            sunt_pkg::S_MIN_CMP: begin
                // r_out.sig holds the weakest signal found so far.
                if (r_idx == '0 || r_rd.sig < r_out.sig) begin
                    n_out.sig = r_rd.sig;
                    n_slot    = r_idx[IW-1:0];
                end
                if (r_idx + CW'(1) < CW'(MAX_ROWS)) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = sunt_pkg::S_MIN_RD;
                end else begin
                    n_state = (r_new.sig > n_out.sig) ? sunt_pkg::S_WRITE
                                                      : sunt_pkg::S_IDLE;
                end
            end
            sunt_pkg::S_WRITE: begin
                wr_en   = 1'b1;
                n_state = sunt_pkg::S_IDLE;
            end
            // Insertion sort: read row i into r_new, then walk j downwards.
            sunt_pkg::S_SORT_RD: begin
                rd_addr = r_outer[IW-1:0];
                n_idx   = r_outer;
                n_state = sunt_pkg::S_SORT_CMP;
                n_slot  = '1;
            end
            sunt_pkg::S_SORT_CMP: begin
                if (r_slot == '1 && r_idx == r_outer) begin
                    n_new  = r_rd;
                    n_slot = '0;
                end
                rd_addr = IW'(r_idx - CW'(1));
                n_state = sunt_pkg::S_SORT_SHIFT;
            end
            sunt_pkg::S_SORT_SHIFT: begin
                // r_rd holds row j-1.
                if (r_rd.sig < r_new.sig) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx[IW-1:0];
                    wr_data = r_rd;
                    n_idx   = r_idx - CW'(1);
                    n_state = (r_idx == CW'(1)) ? sunt_pkg::S_SORT_PUT
                                                : sunt_pkg::S_SORT_CMP;
                end else begin
                    n_state = sunt_pkg::S_SORT_PUT;
                end
            end
            sunt_pkg::S_SORT_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[IW-1:0];
                wr_data = r_new;
                if (r_outer + CW'(1) < r_count) begin
                    n_outer = r_outer + CW'(1);
                    n_state = sunt_pkg::S_SORT_RD;
                end else begin
                    n_idx   = '0;
                    n_state = sunt_pkg::S_EMIT_RD;
                end
            end
            sunt_pkg::S_EMIT_RD: begin
                if (!r_oval || !i_stall) begin
                    n_oval  = 1'b0;
                    n_state = sunt_pkg::S_EMIT_OUT;
                end
            end
            sunt_pkg::S_EMIT_OUT: begin
                n_out   = r_rd;
                n_oval  = 1'b1;
                n_orv   = 1'b1;
                n_olast = (r_idx + CW'(1) == r_count);
                n_idx   = r_idx + CW'(1);
                n_state = n_olast ? sunt_pkg::S_IDLE : sunt_pkg::S_EMIT_RD;
            end
            sunt_pkg::S_EMPTY_OUT: begin
                n_out   = '0;
                n_oval  = 1'b1;
                n_orv   = 1'b0;
                n_olast = 1'b1;
                n_state = sunt_pkg::S_IDLE;
            end
            default: n_state = sunt_pkg::S_IDLE;
        endcase
        // Output register drains independently when taken.
        if (r_oval && !i_stall && r_state != sunt_pkg::S_EMIT_RD &&
            !(r_state == sunt_pkg::S_EMIT_OUT || r_state == sunt_pkg::S_EMPTY_OUT)) begin
            n_oval = 1'b0;
        end
    end

    assign o_valid           = r_oval;
    assign o_out_name_word0  = r_out.w0;
    assign o_out_name_word1  = r_out.w1;
    assign o_out_name_word2  = r_out.w2;
    assign o_out_name_word3  = r_out.w3;
    assign o_out_name_length = r_out.len;
    assign o_out_signal_dbm  = r_out.sig;
    assign o_out_channel     = r_out.chan;
    assign o_out_security    = r_out.sec;
    assign o_row_valid       = r_orv;
    assign o_last_row        = r_olast;

endmodule
